### rtl/rets_pkg.sv
// ----------------------------------------------------------------------------
// rets_pkg - shared constants for the periodic task scheduler
// Action codes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package rets_pkg;

    localparam int MAX_TASKS = 8;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = 4;
    localparam int TIME_W    = 32;
    localparam int VAL_W     = 12;
    localparam int KEY_W     = 45;
    localparam int DIVN_W    = TIME_W + 1;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_COUNT  = 1'b1;

    localparam logic POLICY_RM  = 1'b0;

    typedef logic [KEY_W-1:0] key_t;

endpackage

### rtl/rms_edf_task_scheduler.sv
// ----------------------------------------------------------------------------
// rms_edf_task_scheduler - rate-monotonic / earliest-deadline task scheduler
// Per-task runtime/period and execution counts live in small synchronous
// memories; a sequencer walks the active tasks once per tick beat.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     start & !busy      action, task_index, task_runtime, task_period
//  config    cfg_we             cfg_index, cfg_data
//  result    done (1 cycle)     tick_time, runs, chosen_task, completes,
//                               miss_mask
//
//  A load, restart or unused action beat yields its result in the next cycle
//  and leaves busy low. A tick beat holds busy while it runs the shared
//  33-step serial divider: one divide per active task with nonzero runtime
//  and period for the release count, one more per missed task under EDF,
//  and two for the completion check of the chosen task. A slot with zero
//  runtime or period is skipped without a divide.
//  Reset clears time and the count valid bits, sets the configuration to RM
//  with a task count of one; the task table holds no reset.
//  The receiver cannot stall, so each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module rms_edf_task_scheduler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   action,
    input  logic [rets_pkg::IDX_W-1:0]   task_index,
    input  logic [rets_pkg::VAL_W-1:0]   task_runtime,
    input  logic [rets_pkg::VAL_W-1:0]   task_period,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [rets_pkg::CNT_W-1:0]   cfg_data,
    output logic                         done,
    output logic [rets_pkg::TIME_W-1:0]  tick_time,
    output logic                         runs,
    output logic [2:0]                   chosen_task,
    output logic                         completes,
    output logic [7:0]                   miss_mask
);
    import rets_pkg::*;

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_CMP  = 4'd5;
    localparam logic [3:0] S_MK1  = 4'd6;
    localparam logic [3:0] S_MK2  = 4'd7;
    localparam logic [3:0] S_SEL  = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_FRD  = 4'd10;
    localparam logic [3:0] S_FUP  = 4'd11;
    localparam logic [3:0] S_FD2  = 4'd12;
    localparam logic [3:0] S_FD3  = 4'd13;
    localparam logic [3:0] S_FCMP = 4'd14;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int DCNT_W = $clog2(DIVN_W + 1);
    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(DIVN_W);

    // memories: task table {runtime, period} and execution counts
    logic [2*VAL_W-1:0]  tab_mem [MAX_TASKS];
    logic [TIME_W-1:0]   cnt_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] cnt_vld_reg;
    logic [2*VAL_W-1:0]  tab_q;
    logic [TIME_W-1:0]   cnt_q;
    logic                vld_q;

    logic [3:0]          state_reg, state_next;
    logic [3:0]          ret_reg, ret_next;
    logic                policy_reg;
    logic [CNT_W-1:0]    tcount_reg;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    key_t                best_reg, best_next;
    key_t                key_reg, key_next;
    key_t                prod_reg, prod_next;
    logic [DIVN_W-1:0]   rel_reg, rel_next;
    logic                missed_reg, missed_next;
    logic [MAX_TASKS-1:0] miss_reg, miss_next;
    logic [TIME_W-1:0]   cnew_reg, cnew_next;
    logic                remz_reg, remz_next;

    // serial divider
    logic [DIVN_W-1:0]   dq_reg, dq_next;
    logic [VAL_W-1:0]    dr_reg, dr_next;
    logic [VAL_W-1:0]    dd_reg, dd_next;
    logic [DCNT_W-1:0]   dc_reg, dc_next;
    logic [VAL_W:0]      dtmp;
    logic                dge;

    // result registers
    logic                done_reg, done_next;
    logic [TIME_W-1:0]   otime_reg, otime_next;
    logic                oruns_reg, oruns_next;
    logic [2:0]          ochosen_reg, ochosen_next;
    logic                ocomp_reg, ocomp_next;
    logic [7:0]          omiss_reg, omiss_next;

    logic                tab_we;
    logic                cnt_we;
    logic                vld_clr;
    logic [VAL_W-1:0]    cur_r, cur_p;
    logic [TIME_W-1:0]   cur_c;
    logic                accept;

    assign cur_r  = tab_q[2*VAL_W-1:VAL_W];
    assign cur_p  = tab_q[VAL_W-1:0];
    assign cur_c  = vld_q ? cnt_q : '0;
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign dtmp   = {dr_reg, dq_reg[DIVN_W-1]};
    assign dge    = (dtmp >= {1'b0, dd_reg});

    // table write on a load beat, synchronous read at the walking index
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[task_index] <= {task_runtime, task_period};
        end
        if (cnt_we)
        begin
            cnt_mem[idx_reg] <= cnew_next;
        end
        tab_q <= tab_mem[idx_reg];
        cnt_q <= cnt_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_vld_reg <= '0;
            vld_q       <= 1'b0;
        end
        else
        begin
            vld_q <= cnt_vld_reg[idx_reg];
            if (vld_clr)
            begin
                cnt_vld_reg <= '0;
            end
            else if (cnt_we)
            begin
                cnt_vld_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        ret_next      = ret_reg;
        now_next      = now_reg;
        idx_next      = idx_reg;
        n_next        = n_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        key_next      = key_reg;
        prod_next     = prod_reg;
        rel_next      = rel_reg;
        missed_next   = missed_reg;
        miss_next     = miss_reg;
        cnew_next     = cnew_reg;
        remz_next     = remz_reg;
        dq_next       = dq_reg;
        dr_next       = dr_reg;
        dd_next       = dd_reg;
        dc_next       = dc_reg;
        done_next     = 1'b0;
        otime_next    = otime_reg;
        oruns_next    = oruns_reg;
        ochosen_next  = ochosen_reg;
        ocomp_next    = ocomp_reg;
        omiss_next    = omiss_reg;
        tab_we        = 1'b0;
        cnt_we        = 1'b0;
        vld_clr       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // zero result for every beat that is not a tick
                    otime_next   = '0;
                    oruns_next   = 1'b0;
                    ochosen_next = '0;
                    ocomp_next   = 1'b0;
                    omiss_next   = '0;
                    case (action)
                        ACT_LOAD:
                        begin
                            tab_we    = 1'b1;
                            done_next = 1'b1;
                        end
                        ACT_RESTART:
                        begin
                            vld_clr   = 1'b1;
                            now_next  = '0;
                            done_next = 1'b1;
                        end
                        ACT_TICK:
                        begin
                            n_next     = (tcount_reg > CNT_W'(MAX_TASKS))
                                         ? CNT_W'(MAX_TASKS) : tcount_reg;
                            idx_next   = '0;
                            found_next = 1'b0;
                            miss_next  = '0;
                            state_next = (n_next == '0) ? S_FIN : S_RD;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (cur_r == '0 || cur_p == '0)
                begin
                    state_next = S_SEL;
                    key_next   = '1;
                    missed_next = 1'b0;
                    prod_next  = '0;
                    // skip: flag as not eligible through found path below
                    rel_next   = '0;
                    ret_next   = S_IDLE;
                end
                else
                begin
                    dq_next    = {1'b0, now_reg};
                    dr_next    = '0;
                    dd_next    = cur_p;
                    dc_next    = DIV_STEPS;
                    ret_next   = S_MUL;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                dr_next = dge ? VAL_W'(dtmp - {1'b0, dd_reg}) : dtmp[VAL_W-1:0];
                dq_next = {dq_reg[DIVN_W-2:0], dge};
                dc_next = dc_reg - 1'b1;
                if (dc_reg == DCNT_W'(1))
                begin
                    state_next = ret_reg;
                end
            end
            S_MUL:
            begin
                rel_next  = dq_reg;
                prod_next = KEY_W'(cur_r * dq_reg[TIME_W-1:0]);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                missed_next = (now_reg != '0) && ({13'd0, cur_c} < prod_reg);
                if (missed_next)
                begin
                    miss_next[idx_reg] = 1'b1;
                end
                if (!({13'd0, cur_c} < prod_reg + {33'd0, cur_r}))
                begin
                    ret_next   = S_IDLE;
                    state_next = S_SEL;
                end
                else if (policy_reg == POLICY_RM)
                begin
                    key_next   = {33'd0, cur_p};
                    ret_next   = S_CMP;
                    state_next = S_SEL;
                end
                else if (missed_next)
                begin
                    dq_next    = {1'b0, cur_c};
                    dr_next    = '0;
                    dd_next    = cur_r;
                    dc_next    = DIV_STEPS;
                    ret_next   = S_MK2;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_MK1;
                end
            end
            S_MK1:
            begin
                key_next   = KEY_W'(cur_p * (rel_reg + 1'b1));
                ret_next   = S_CMP;
                state_next = S_SEL;
            end
            S_MK2:
            begin
                key_next   = KEY_W'(cur_p * (dq_reg + 1'b1));
                ret_next   = S_CMP;
                state_next = S_SEL;
            end
            S_SEL:
            begin
                // ret_reg marks an eligible candidate; anything else is skipped
                if (ret_reg == S_CMP && (!found_reg || key_reg < best_reg))
                begin
                    found_next    = 1'b1;
                    best_next     = key_reg;
                    best_idx_next = idx_reg;
                end
                if ({1'b0, idx_reg} == n_reg - 1'b1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                if (!found_reg)
                begin
                    otime_next   = now_reg;
                    oruns_next   = 1'b0;
                    ochosen_next = '0;
                    ocomp_next   = 1'b0;
                    omiss_next   = miss_reg[7:0];
                    done_next    = 1'b1;
                    if (now_reg != TIME_MAX)
                    begin
                        now_next = now_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = best_idx_reg;
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                state_next = S_FUP;
            end
            S_FUP:
            begin
                cnew_next  = (cur_c == TIME_MAX) ? cur_c : cur_c + 1'b1;
                cnt_we     = 1'b1;
                dq_next    = {1'b0, cnew_next};
                dr_next    = '0;
                dd_next    = cur_r;
                dc_next    = DIV_STEPS;
                ret_next   = S_FD2;
                state_next = S_DIV;
            end
            S_FD2:
            begin
                remz_next  = (dr_reg == '0);
                dq_next    = {1'b0, now_reg} + 1'b1;
                dr_next    = '0;
                dd_next    = cur_p;
                dc_next    = DIV_STEPS;
                ret_next   = S_FD3;
                state_next = S_DIV;
            end
            S_FD3:
            begin
                prod_next  = KEY_W'(cur_r * (dq_reg + 1'b1));
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                otime_next   = now_reg;
                oruns_next   = 1'b1;
                ochosen_next = 3'(best_idx_reg);
                ocomp_next   = remz_reg && (prod_reg >= {13'd0, cnew_reg});
                omiss_next   = miss_reg[7:0];
                done_next    = 1'b1;
                if (now_reg != TIME_MAX)
                begin
                    now_next = now_reg + 1'b1;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            policy_reg <= POLICY_RM;
            tcount_reg <= CNT_W'(1);
            now_reg    <= '0;
            found_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            now_reg   <= now_next;
            found_reg <= found_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POLICY: policy_reg <= cfg_data[0];
                    CFG_COUNT:  tcount_reg <= cfg_data;
                    default:    policy_reg <= policy_reg;
                endcase
            end
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        key_reg      <= key_next;
        prod_reg     <= prod_next;
        rel_reg      <= rel_next;
        missed_reg   <= missed_next;
        miss_reg     <= miss_next;
        cnew_reg     <= cnew_next;
        remz_reg     <= remz_next;
        dq_reg       <= dq_next;
        dr_reg       <= dr_next;
        dd_reg       <= dd_next;
        dc_reg       <= dc_next;
        otime_reg    <= otime_next;
        oruns_reg    <= oruns_next;
        ochosen_reg  <= ochosen_next;
        ocomp_reg    <= ocomp_next;
        omiss_reg    <= omiss_next;
    end

    assign done        = done_reg;
    assign tick_time   = otime_reg;
    assign runs        = oruns_reg;
    assign chosen_task = ochosen_reg;
    assign completes   = ocomp_reg;
    assign miss_mask   = omiss_reg;

`ifndef NO_ASSERTIONS
    // a result beat always lands with the sequencer back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result while busy");
    // no task index or completion without a running task
    a_norun: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !runs) |-> (chosen_task == '0 && !completes))
        else $error("idle tick reports a task");
    // a load beat answers next cycle with an all-zero result
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action == ACT_LOAD) |=>
        (done && !runs && tick_time == '0 && miss_mask == '0))
        else $error("load result wrong");
`endif

endmodule

### verif/tb_rms_edf_task_scheduler.sv
// ----------------------------------------------------------------------------
// tb_rms_edf_task_scheduler - self-checking bench for the task scheduler
// Drives load, tick, restart and spare beats with random gaps, changes the
// policy and task count between phases, and checks every result against
// the bench's own cycle-free model of both scheduling policies.
// ----------------------------------------------------------------------------
module tb_rms_edf_task_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    import rets_pkg::*;

    // Action code with no meaning: the block must answer with an all-zero result
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int ITEM_TARGET     = 1000;

    typedef struct packed {
        logic [31:0] tick_time;
        logic        runs;
        logic [2:0]  chosen_task;
        logic        completes;
        logic [7:0]  miss_mask;
    } sched_result_t;

    // Holds its own copy of the schedule state and predicts one result per beat
    class sched_scoreboard;
        bit             policy_edf;
        bit [3:0]       active_tasks;
        bit [31:0]      now_ticks;
        bit [31:0]      exec_count [MAX_TASKS];
        bit [11:0]      runtime_of [MAX_TASKS];
        bit [11:0]      period_of  [MAX_TASKS];
        sched_result_t  awaited [$];
        int             errors;

        function new();
            policy_edf   = 1'b0;
            active_tasks = 4'd1;
            now_ticks    = '0;
            errors       = 0;
            foreach (exec_count[i])
            begin
                exec_count[i] = '0;
                runtime_of[i] = '0;
                period_of[i]  = '0;
            end
        endfunction

        function void write_reg(logic index, logic [3:0] value);
            if (index == CFG_POLICY)
                policy_edf = value[0];
            else
                active_tasks = value;
        endfunction

        // Predict the result of one accepted input beat
        function void note_item(logic [1:0] act, logic [2:0] slot,
                                logic [11:0] run_ticks, logic [11:0] per_ticks);
            sched_result_t     res;
            int                n;
            int                pick;
            bit                found;
            longint unsigned   t, r, p, c, rel, key, best;
            bit                missed;

            res   = '0;
            found = 1'b0;
            pick  = 0;
            best  = 0;
            if (act == ACT_LOAD)
            begin
                runtime_of[slot] = run_ticks;
                period_of[slot]  = per_ticks;
            end
            else if (act == ACT_RESTART)
            begin
                now_ticks = '0;
                foreach (exec_count[i])
                    exec_count[i] = '0;
            end
            else if (act == ACT_TICK)
            begin
                t = now_ticks;
                n = (active_tasks > MAX_TASKS) ? MAX_TASKS : active_tasks;
                for (int i = 0; i < n; i++)
                begin
                    r = runtime_of[i];
                    p = period_of[i];
                    c = exec_count[i];
                    if (r == 0 || p == 0)
                        continue;
                    rel    = t / p;
                    missed = (t != 0) && (c < r * rel);
                    if (missed)
                        res.miss_mask[i] = 1'b1;
                    if (!(c < r * (rel + 1)))
                        continue;
                    if (!policy_edf)
                        key = p;
                    else
                        key = missed ? (c / r + 1) * p : p * (rel + 1);
                    if (!found || key < best)
                    begin
                        found = 1'b1;
                        best  = key;
                        pick  = i;
                    end
                end
                if (found)
                begin
                    if (exec_count[pick] != 32'hFFFF_FFFF)
                        exec_count[pick]++;
                    r = runtime_of[pick];
                    p = period_of[pick];
                    c = exec_count[pick];
                    res.runs        = 1'b1;
                    res.chosen_task = pick[2:0];
                    res.completes   = (c % r == 0) && (r * (1 + (t + 1) / p) >= c);
                end
                res.tick_time = t[31:0];
                if (now_ticks != 32'hFFFF_FFFF)
                    now_ticks++;
            end
            awaited.push_back(res);
        endfunction

        function void check_result(sched_result_t got);
            sched_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result beat with nothing awaited");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.tick_time != want.tick_time)
            begin
                $error("tick_time: expected %0d, got %0d", want.tick_time, got.tick_time);
                errors++;
            end
            if (got.runs != want.runs)
            begin
                $error("runs: expected %0d, got %0d", want.runs, got.runs);
                errors++;
            end
            if (got.chosen_task != want.chosen_task)
            begin
                $error("chosen_task: expected %0d, got %0d", want.chosen_task,
                       got.chosen_task);
                errors++;
            end
            if (got.completes != want.completes)
            begin
                $error("completes: expected %0d, got %0d", want.completes, got.completes);
                errors++;
            end
            if (got.miss_mask != want.miss_mask)
            begin
                $error("miss_mask: expected %h, got %h", want.miss_mask, got.miss_mask);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          action;
    logic [IDX_W-1:0]    task_index;
    logic [VAL_W-1:0]    task_runtime;
    logic [VAL_W-1:0]    task_period;
    logic                cfg_we;
    logic                cfg_index;
    logic [CNT_W-1:0]    cfg_data;
    logic                done;
    logic [TIME_W-1:0]   tick_time;
    logic                runs;
    logic [2:0]          chosen_task;
    logic                completes;
    logic [7:0]          miss_mask;

    sched_scoreboard sb;
    int              items_sent;
    int              quiet_cycles;
    bit              no_gaps;

    rms_edf_task_scheduler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .task_index   (task_index),
        .task_runtime (task_runtime),
        .task_period  (task_period),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .tick_time    (tick_time),
        .runs         (runs),
        .chosen_task  (chosen_task),
        .completes    (completes),
        .miss_mask    (miss_mask)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every result beat; the receiver never stalls, so sample each edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result({tick_time, runs, chosen_task, completes, miss_mask});
    end

    // Watchdog: count cycles in which neither an input nor a result beat moves
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one input beat after a random gap; hold start until it is taken
    task automatic send_item(logic [1:0] act, logic [2:0] slot,
                             logic [11:0] run_ticks, logic [11:0] per_ticks);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        action       <= act;
        task_index   <= slot;
        task_runtime <= run_ticks;
        task_period  <= per_ticks;
        do
            @(posedge clk);
        while (busy);
        sb.note_item(act, slot, run_ticks, per_ticks);
        items_sent++;
    endtask

    // Drop start and wait until every awaited result has arrived
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic index, logic [3:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_reg(index, value);
        @(posedge clk);
    endtask

    // Random load: mostly short periods so that overload and misses occur
    task automatic send_random_load();
        logic [11:0] r, p;
        case ($urandom_range(0, 9))
            0:
            begin
                r = 12'($urandom_range(0, 4095));
                p = 12'($urandom_range(0, 4095));
            end
            1:
            begin
                r = 12'($urandom_range(1, 3));
                p = 12'($urandom_range(1000, 4095));
            end
            default:
            begin
                r = 12'($urandom_range(1, 6));
                p = 12'($urandom_range(1, 24));
            end
        endcase
        send_item(ACT_LOAD, 3'($urandom_range(0, 7)), r, p);
    endtask

    initial
    begin
        int ticks;
        int pick;

        sb           = new();
        items_sent   = 0;
        no_gaps      = 1'b0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        action       <= ACT_LOAD;
        task_index   <= '0;
        task_runtime <= '0;
        task_period  <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_POLICY;
        cfg_data     <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: fill every slot first so no tick reads an unloaded entry
        send_item(ACT_LOAD, 3'd0, 12'd1,    12'd1);
        send_item(ACT_LOAD, 3'd1, 12'd4095, 12'd4095);
        send_item(ACT_LOAD, 3'd2, 12'd0,    12'd5);   // zero runtime: never runs
        send_item(ACT_LOAD, 3'd3, 12'd2,    12'd0);   // zero period: never runs
        send_item(ACT_LOAD, 3'd4, 12'd2,    12'd3);
        send_item(ACT_LOAD, 3'd5, 12'd1,    12'd2);
        send_item(ACT_LOAD, 3'd6, 12'd3,    12'd4);
        send_item(ACT_LOAD, 3'd7, 12'd2,    12'd5);
        send_item(ACT_SPARE, 3'd7, 12'hFFF, 12'hFFF);
        send_item(ACT_TICK, 3'd0, 12'd0, 12'd0);      // reset task count of one
        send_item(ACT_TICK, 3'd0, 12'd0, 12'd0);
        drain();
        write_reg(CFG_COUNT, 4'd8);
        repeat (5) send_item(ACT_TICK, 3'd0, 12'd0, 12'd0);
        drain();
        write_reg(CFG_POLICY, 4'd1);
        write_reg(CFG_COUNT, 4'd15);                  // saturates to all slots
        repeat (5) send_item(ACT_TICK, 3'd0, 12'd0, 12'd0);
        send_item(ACT_RESTART, 3'd0, 12'd0, 12'd0);
        drain();
        write_reg(CFG_COUNT, 4'd0);                   // no active tasks
        send_item(ACT_TICK, 3'd0, 12'd0, 12'd0);
        drain();

        // Random phases: new settings, restart, reload, then mostly ticks
        while (items_sent < ITEM_TARGET)
        begin
            no_gaps = ($urandom_range(0, 4) == 0);
            write_reg(CFG_POLICY, 4'($urandom_range(0, 1)));
            pick = $urandom_range(0, 9);
            write_reg(CFG_COUNT, (pick == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 4)));
            send_item(ACT_RESTART, 3'd0, 12'd0, 12'd0);
            repeat ($urandom_range(1, 4)) send_random_load();
            ticks = $urandom_range(20, 60);
            repeat (ticks)
            begin
                pick = $urandom_range(0, 39);
                if (pick == 0)
                    send_item(ACT_RESTART, 3'($urandom_range(0, 7)),
                              12'($urandom), 12'($urandom));
                else if (pick == 1)
                    send_item(ACT_SPARE, 3'($urandom_range(0, 7)),
                              12'($urandom), 12'($urandom));
                else if (pick < 4)
                    send_random_load();
                else
                    send_item(ACT_TICK, 3'($urandom_range(0, 7)),
                              12'($urandom), 12'($urandom));
            end
            // Pause the sender until the block has answered everything
            drain();
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
